>>> sv/median_filter_2d_mirror_pad_assert.svh
// assertion macros for the median filter checker
`ifndef MEDIAN_FILTER_2D_MIRROR_PAD_ASSERT_SVH
`define MEDIAN_FILTER_2D_MIRROR_PAD_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define MF2D_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mf2d check failed");

// next-cycle implication, sampled on clk, off during reset
`define MF2D_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mf2d check failed");

`endif

>>> sv/mf2d_pkg.sv
// shared types, constants and the mirror fold function of the median filter
package mf2d_pkg;

    // parameter defaults
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_SIDE_DEF   = 7;
    localparam int PIXEL_BITS_DEF = 8;

    // fixed field widths
    localparam int W_W       = 11;
    localparam int H_W       = 12;
    localparam int K_W       = 3;
    localparam int ROW_W     = 12;
    localparam int COL_W     = 11;
    localparam int P_W       = ROW_W + 2;
    localparam int POS_W     = 24;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int PIX_IN_W  = 8;
    localparam int OUT_COL_W = 10;

    // reset values of the configuration registers
    localparam logic [W_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [H_W-1:0] HEIGHT_RST = 12'd480;
    localparam logic [K_W-1:0] SIDE_RST   = 3'd3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_SIDE   = 2'd2
    } cfg_idx_t;

    // effective (clamped) frame geometry
    typedef struct packed {
        logic [W_W-1:0] w;
        logic [H_W-1:0] h;
        logic [K_W-1:0] k;
    } geom_t;

    // one output position handed from front to back
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] seq;
        logic             last;
    } job_t;

    // half-sample mirror of a coordinate into 0..n-1, clamped if still outside
    function automatic logic [ROW_W-1:0] fold(input logic signed [P_W-1:0] p,
                                              input logic [ROW_W:0] n);
        logic signed [P_W-1:0] q;
        logic signed [P_W-1:0] nn;
        nn = signed'({1'b0, n});
        q  = (p < 0) ? ~p : p;
        if (q >= nn)
        begin
            q = (nn <<< 1) - P_W'(1) - q;
        end
        if (q < 0)
        begin
            q = '0;
        end
        if (q >= nn)
        begin
            q = nn - P_W'(1);
        end
        return q[ROW_W-1:0];
    endfunction

endpackage

>>> sv/mf2d_front.sv
// front end: configuration registers, input counters, line store writes, job issue
module mf2d_front #(
    parameter int MAX_WIDTH  = mf2d_pkg::MAX_WIDTH_DEF,
    parameter int MAX_SIDE   = mf2d_pkg::MAX_SIDE_DEF,
    parameter int PIXEL_BITS = mf2d_pkg::PIXEL_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mf2d_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mf2d_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                op,
    input  logic [mf2d_pkg::PIX_IN_W-1:0]       pixel,
    input  logic                                q_full,
    output logic                                push,
    output mf2d_pkg::job_t                      push_job,
    output mf2d_pkg::geom_t                     geom,
    output logic                                wr_en,
    output logic [$clog2((2**$clog2(MAX_SIDE+1))*MAX_WIDTH)-1:0] wr_addr,
    output logic [PIXEL_BITS-1:0]               wr_data
);

    localparam int NSLOT  = 2**$clog2(MAX_SIDE + 1);
    localparam int SLOT_W = $clog2(NSLOT);
    localparam int ADDR_W = $clog2(NSLOT * MAX_WIDTH);

    logic [mf2d_pkg::W_W-1:0]   cfg_w_reg, cfg_w_next;
    logic [mf2d_pkg::H_W-1:0]   cfg_h_reg, cfg_h_next;
    logic [mf2d_pkg::K_W-1:0]   cfg_k_reg, cfg_k_next;
    logic [mf2d_pkg::ROW_W-1:0] in_row_reg, in_row_next;
    logic [mf2d_pkg::COL_W-1:0] in_col_reg, in_col_next;
    logic [mf2d_pkg::POS_W-1:0] rx_reg, rx_next;
    logic [mf2d_pkg::ROW_W-1:0] em_row_reg, em_row_next;
    logic [mf2d_pkg::COL_W-1:0] em_col_reg, em_col_next;
    logic [mf2d_pkg::POS_W-1:0] em_reg, em_next;
    logic [mf2d_pkg::ROW_W-1:0] wseq_reg, wseq_next;
    logic [mf2d_pkg::ROW_W-1:0] eseq_reg, eseq_next;

    logic [mf2d_pkg::W_W-1:0]   w;
    logic [mf2d_pkg::H_W-1:0]   h;
    logic [mf2d_pkg::K_W-1:0]   k;
    logic [1:0]                 half;
    logic [mf2d_pkg::POS_W-1:0] lag;
    logic                       accept;

    // clamp the raw register values
    always_comb
    begin
        w = (cfg_w_reg == '0) ? mf2d_pkg::W_W'(1) :
            ((13'(cfg_w_reg) > 13'(MAX_WIDTH)) ? mf2d_pkg::W_W'(MAX_WIDTH) : cfg_w_reg);
        h = (cfg_h_reg == '0) ? mf2d_pkg::H_W'(1) : cfg_h_reg;
        k = (cfg_k_reg == '0) ? mf2d_pkg::K_W'(1) :
            ((5'(cfg_k_reg) > 5'(MAX_SIDE)) ? mf2d_pkg::K_W'(MAX_SIDE) : cfg_k_reg);
        half = k[2:1];
        lag  = mf2d_pkg::POS_W'(half) * mf2d_pkg::POS_W'(w) + mf2d_pkg::POS_W'(half);
    end

    assign geom     = '{w: w, h: h, k: k};
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign wr_data  = PIXEL_BITS'(pixel);
    assign wr_addr  = ADDR_W'(wseq_reg[SLOT_W-1:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col_reg);

    // input bookkeeping, emit decision and restart
    always_comb
    begin
        cfg_w_next  = cfg_w_reg;
        cfg_h_next  = cfg_h_reg;
        cfg_k_next  = cfg_k_reg;
        in_row_next = in_row_reg;
        in_col_next = in_col_reg;
        rx_next     = rx_reg;
        em_row_next = em_row_reg;
        em_col_next = em_col_reg;
        em_next     = em_reg;
        wseq_next   = wseq_reg;
        eseq_next   = eseq_reg;
        wr_en       = 1'b0;
        push        = 1'b0;
        push_job    = '{row: em_row_reg, col: em_col_reg, seq: eseq_reg,
                        last: (em_row_reg == h - 1'b1) && (em_col_reg == w - 1'b1)};

        // pixel write while the frame is still arriving
        if (accept && !op && (in_row_reg < h))
        begin
            wr_en       = 1'b1;
            rx_next     = rx_reg + 1'b1;
            in_col_next = in_col_reg + 1'b1;
            if (in_col_next >= w)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + 1'b1;
                wseq_next   = wseq_reg + 1'b1;
            end
        end

        // issue the next output position once its window has arrived
        if (accept && (em_row_reg < h) && ((in_row_next >= h) || (rx_next > em_reg + lag)))
        begin
            push        = 1'b1;
            em_next     = em_reg + 1'b1;
            em_col_next = em_col_reg + 1'b1;
            if (em_col_next >= w)
            begin
                em_col_next = '0;
                em_row_next = em_row_reg + 1'b1;
                eseq_next   = eseq_reg + 1'b1;
            end
            if (em_row_next >= h)
            begin
                in_row_next = '0;
                in_col_next = '0;
                rx_next     = '0;
                em_row_next = '0;
                em_col_next = '0;
                em_next     = '0;
            end
        end

        // a write to the width, height or side register restarts the frame
        if (cfg_we)
        begin
            unique case (cfg_index)
                mf2d_pkg::CFG_WIDTH:  cfg_w_next = cfg_data[mf2d_pkg::W_W-1:0];
                mf2d_pkg::CFG_HEIGHT: cfg_h_next = cfg_data[mf2d_pkg::H_W-1:0];
                mf2d_pkg::CFG_SIDE:   cfg_k_next = cfg_data[mf2d_pkg::K_W-1:0];
                default:              ;
            endcase
            if (cfg_index == mf2d_pkg::CFG_WIDTH || cfg_index == mf2d_pkg::CFG_HEIGHT ||
                cfg_index == mf2d_pkg::CFG_SIDE)
            begin
                in_row_next = '0;
                in_col_next = '0;
                rx_next     = '0;
                em_row_next = '0;
                em_col_next = '0;
                em_next     = '0;
                eseq_next   = wseq_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_w_reg  <= mf2d_pkg::WIDTH_RST;
            cfg_h_reg  <= mf2d_pkg::HEIGHT_RST;
            cfg_k_reg  <= mf2d_pkg::SIDE_RST;
            in_row_reg <= '0;
            in_col_reg <= '0;
            rx_reg     <= '0;
            em_row_reg <= '0;
            em_col_reg <= '0;
            em_reg     <= '0;
            wseq_reg   <= '0;
            eseq_reg   <= '0;
        end
        else
        begin
            cfg_w_reg  <= cfg_w_next;
            cfg_h_reg  <= cfg_h_next;
            cfg_k_reg  <= cfg_k_next;
            in_row_reg <= in_row_next;
            in_col_reg <= in_col_next;
            rx_reg     <= rx_next;
            em_row_reg <= em_row_next;
            em_col_reg <= em_col_next;
            em_reg     <= em_next;
            wseq_reg   <= wseq_next;
            eseq_reg   <= eseq_next;
        end
    end

endmodule

>>> sv/mf2d_jobq.sv
// one-entry queue of output positions between front and back
module mf2d_jobq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mf2d_pkg::job_t push_job,
    input  logic           pop,
    output logic           full,
    output mf2d_pkg::job_t job
);

    logic           valid_reg, valid_next;
    mf2d_pkg::job_t job_reg, job_next;

    // push only happens while empty
    always_comb
    begin
        valid_next = valid_reg;
        job_next   = job_reg;
        if (push)
        begin
            valid_next = 1'b1;
            job_next   = push_job;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    assign full = valid_reg;
    assign job  = job_reg;

endmodule

>>> sv/mf2d_back.sv
// back end: line store, window walk, insertion sorter and output register
module mf2d_back #(
    parameter int MAX_WIDTH  = mf2d_pkg::MAX_WIDTH_DEF,
    parameter int MAX_SIDE   = mf2d_pkg::MAX_SIDE_DEF,
    parameter int PIXEL_BITS = mf2d_pkg::PIXEL_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mf2d_pkg::geom_t                     geom,
    input  logic                                q_valid,
    input  mf2d_pkg::job_t                      q_job,
    output logic                                pop,
    input  logic                                wr_en,
    input  logic [$clog2((2**$clog2(MAX_SIDE+1))*MAX_WIDTH)-1:0] wr_addr,
    input  logic [PIXEL_BITS-1:0]               wr_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [mf2d_pkg::PIX_IN_W-1:0]       value,
    output logic [mf2d_pkg::ROW_W-1:0]          out_row,
    output logic [mf2d_pkg::OUT_COL_W-1:0]      out_col,
    output logic                                frame_end
);

    localparam int NSLOT  = 2**$clog2(MAX_SIDE + 1);
    localparam int SLOT_W = $clog2(NSLOT);
    localparam int ADDR_W = $clog2(NSLOT * MAX_WIDTH);
    localparam int DEPTH  = NSLOT * MAX_WIDTH;
    localparam int NCELL  = (MAX_SIDE * MAX_SIDE - 1) / 2 + 1;
    localparam int M_W    = $clog2(NCELL);
    localparam int FILL_W = $clog2(NCELL + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_DONE} state_t;

    state_t                          state_reg, state_next;
    mf2d_pkg::job_t                  job_reg, job_next;
    logic signed [mf2d_pkg::P_W-1:0] prow_reg, prow_next;
    logic signed [mf2d_pkg::P_W-1:0] pcol_reg, pcol_next;
    logic signed [mf2d_pkg::P_W-1:0] pcol0_reg, pcol0_next;
    logic [mf2d_pkg::K_W-1:0]        i_reg, i_next;
    logic [mf2d_pkg::K_W-1:0]        j_reg, j_next;
    logic [M_W-1:0]                  m_reg, m_next;
    logic                            v1_reg, v1_next;
    logic                            last1_reg, last1_next;
    logic [mf2d_pkg::ROW_W-1:0]      fr_reg, fr_next;
    logic [mf2d_pkg::COL_W-1:0]      fc_reg, fc_next;
    logic                            v2_reg, v2_next;
    logic                            last2_reg, last2_next;
    logic [PIXEL_BITS-1:0]           rdata_reg;
    logic [PIXEL_BITS-1:0]           cells_reg [NCELL];
    logic [PIXEL_BITS-1:0]           cells_next [NCELL];
    logic [PIXEL_BITS-1:0]           cells_prev [NCELL];
    logic [FILL_W-1:0]               fill_reg, fill_next;
    logic                            out_valid_reg, out_valid_next;
    logic [mf2d_pkg::PIX_IN_W-1:0]   value_reg, value_next;
    logic [mf2d_pkg::ROW_W-1:0]      out_row_reg, out_row_next;
    logic [mf2d_pkg::OUT_COL_W-1:0]  out_col_reg, out_col_next;
    logic                            frame_end_reg, frame_end_next;

    logic [PIXEL_BITS-1:0]           mem [DEPTH];
    logic [ADDR_W-1:0]               rd_addr;
    logic [SLOT_W-1:0]               rd_slot;
    logic [mf2d_pkg::ROW_W-1:0]      fcol_full;
    logic [NCELL-1:0]                gt;
    logic [NCELL-1:0]                gt_prev;
    logic [1:0]                      s;
    logic                            run_last;
    logic [5:0]                      kk;

    // window row slot is relative to the slot of the output row
    assign rd_slot = SLOT_W'(job_reg.seq[SLOT_W-1:0] + fr_reg[SLOT_W-1:0]
                             - job_reg.row[SLOT_W-1:0]);
    assign rd_addr = ADDR_W'(rd_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(fc_reg);

    // line store: one write port from the front, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_comb
    begin
        s         = 2'((geom.k - 1'b1) >> 1);
        kk        = 6'(geom.k) * 6'(geom.k);
        run_last  = (i_reg == geom.k - 1'b1) && (j_reg == geom.k - 1'b1);
        fcol_full = mf2d_pkg::fold(pcol_reg, {2'b00, geom.w});

        state_next     = state_reg;
        job_next       = job_reg;
        prow_next      = prow_reg;
        pcol_next      = pcol_reg;
        pcol0_next     = pcol0_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        m_next         = m_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        frame_end_next = frame_end_reg;
        pop            = 1'b0;

        // fold stage
        v1_next    = (state_reg == ST_RUN);
        last1_next = run_last;
        fr_next    = mf2d_pkg::fold(prow_reg, {1'b0, geom.h});
        fc_next    = fcol_full[mf2d_pkg::COL_W-1:0];

        // read stage
        v2_next    = v1_reg;
        last2_next = last1_reg;

        // insertion sorter keeps the smallest values in order
        for (int i = 0; i < NCELL; i++)
        begin
            gt[i] = (FILL_W'(i) >= fill_reg) || (cells_reg[i] > rdata_reg);
        end
        gt_prev       = {gt[NCELL-2:0], 1'b0};
        cells_prev[0] = rdata_reg;
        for (int i = 1; i < NCELL; i++)
        begin
            cells_prev[i] = cells_reg[i-1];
        end
        for (int i = 0; i < NCELL; i++)
        begin
            cells_next[i] = cells_reg[i];
            if (v2_reg && gt[i])
            begin
                cells_next[i] = gt_prev[i] ? cells_prev[i] : rdata_reg;
            end
        end
        if (v2_reg && (fill_reg < FILL_W'(NCELL)))
        begin
            fill_next = fill_reg + 1'b1;
        end

        // output register drains independently
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    pop        = 1'b1;
                    job_next   = q_job;
                    prow_next  = signed'(mf2d_pkg::P_W'(q_job.row) - mf2d_pkg::P_W'(s));
                    pcol0_next = signed'(mf2d_pkg::P_W'(q_job.col) - mf2d_pkg::P_W'(s));
                    pcol_next  = signed'(mf2d_pkg::P_W'(q_job.col) - mf2d_pkg::P_W'(s));
                    i_next     = '0;
                    j_next     = '0;
                    m_next     = M_W'((kk - 1'b1) >> 1);
                    fill_next  = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (run_last)
                begin
                    state_next = ST_DRAIN;
                end
                else if (j_reg == geom.k - 1'b1)
                begin
                    j_next    = '0;
                    i_next    = i_reg + 1'b1;
                    prow_next = prow_reg + 1'b1;
                    pcol_next = pcol0_reg;
                end
                else
                begin
                    j_next    = j_reg + 1'b1;
                    pcol_next = pcol_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (v2_reg && last2_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    value_next     = mf2d_pkg::PIX_IN_W'(cells_reg[m_reg]);
                    out_row_next   = job_reg.row;
                    out_col_next   = mf2d_pkg::OUT_COL_W'(job_reg.col);
                    frame_end_next = job_reg.last;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        job_reg       <= job_next;
        prow_reg      <= prow_next;
        pcol_reg      <= pcol_next;
        pcol0_reg     <= pcol0_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        m_reg         <= m_next;
        last1_reg     <= last1_next;
        fr_reg        <= fr_next;
        fc_reg        <= fc_next;
        last2_reg     <= last2_next;
        fill_reg      <= fill_next;
        cells_reg     <= cells_next;
        value_reg     <= value_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        frame_end_reg <= frame_end_next;
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign frame_end = frame_end_reg;

endmodule

>>> sv/median_filter_2d_mirror_pad.sv
// top level of the streaming 2-D median filter with mirrored edges
// Streaming median filter over a k x k window (k = window_side) with half-sample
// mirrored borders. Pixels come in raster order; each output appears once its
// window has arrived, and drain items (op = 1) flush the last outputs of a frame.
// The front takes one item per cycle while its one-entry job queue has room;
// each result is then paced in the back end by the single read port of the line
// store, which feeds one window value a cycle into the insertion sorter. The output
// register lets the back end start the next window while a result waits. A write to
// the width, height or side register restarts the frame.
module median_filter_2d_mirror_pad #(
    parameter int MAX_WIDTH  = mf2d_pkg::MAX_WIDTH_DEF,
    parameter int MAX_SIDE   = mf2d_pkg::MAX_SIDE_DEF,
    parameter int PIXEL_BITS = mf2d_pkg::PIXEL_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mf2d_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mf2d_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             op,
    input  logic [mf2d_pkg::PIX_IN_W-1:0]    pixel,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [mf2d_pkg::PIX_IN_W-1:0]    value,
    output logic [mf2d_pkg::ROW_W-1:0]       out_row,
    output logic [mf2d_pkg::OUT_COL_W-1:0]   out_col,
    output logic                             frame_end
);

    localparam int ADDR_W = $clog2((2**$clog2(MAX_SIDE + 1)) * MAX_WIDTH);

    logic                  q_full;
    logic                  push;
    logic                  pop;
    mf2d_pkg::job_t        push_job;
    mf2d_pkg::job_t        q_job;
    mf2d_pkg::geom_t       geom;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [PIXEL_BITS-1:0] wr_data;

    // input side
    mf2d_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_SIDE   (MAX_SIDE),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .pixel     (pixel),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job),
        .geom      (geom),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // job queue
    mf2d_jobq u_jobq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (q_full),
        .job      (q_job)
    );

    // window gather and median
    mf2d_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_SIDE   (MAX_SIDE),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .geom      (geom),
        .q_valid   (q_full),
        .q_job     (q_job),
        .pop       (pop),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .out_row   (out_row),
        .out_col   (out_col),
        .frame_end (frame_end)
    );

endmodule

>>> sv/mf2d_checker.sv
// port-level checker for the median filter, bound to the top level
`include "median_filter_2d_mirror_pad_assert.svh"

module mf2d_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [mf2d_pkg::PIX_IN_W-1:0]  value,
    input logic [mf2d_pkg::ROW_W-1:0]     out_row,
    input logic [mf2d_pkg::OUT_COL_W-1:0] out_col,
    input logic                           frame_end
);

    // a stalled result stays put
    `MF2D_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(value) && $stable(out_row) && $stable(out_col) && $stable(frame_end))

    // the queue only fills after an input transfer
    `MF2D_ASSERT_NOW(a_stall_cause, $rose(in_stall), $past(in_valid) && !$past(in_stall))

    // reset leaves both channels empty
    `MF2D_ASSERT_NOW(a_reset_clear, $rose(rst_n), !out_valid && !in_stall)

endmodule

bind median_filter_2d_mirror_pad mf2d_checker u_mf2d_checker (.*);
